[hw/rtl/i2cmbe_pkg.sv]
// Shared types and constants for the I2C master byte engine.
`timescale 1ns / 1ps

package i2cmbe_pkg;

    // Action and sequence codes; an action code doubles as the sequence it starts
    localparam logic [2:0] OP_IDLE  = 3'd0;  // also the tick action
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_WAIT  = 3'd5;
    localparam logic [2:0] OP_ACK   = 3'd6;
    localparam logic [2:0] OP_NACK  = 3'd7;

    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
    localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

    // Classified beat handed from the front end to the engine
    typedef struct packed {
        logic       is_cmd;   // command beat, else a tick
        logic [2:0] op;
        logic [7:0] data;
        logic       ackr;
        logic       sda;
    } item_t;

endpackage

[hw/rtl/i2cmbe_front.sv]
// Front end: classifies input beats and pushes them into the queue.
`timescale 1ns / 1ps

module i2cmbe_front (
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          action,
    input  logic [7:0]          data_byte,
    input  logic                ack_after_read,
    input  logic                sda_in,
    output logic                push,
    output i2cmbe_pkg::item_t   push_item,
    input  logic                q_full
);

    // Accept whenever the queue has room
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // Tick or command; fields that the class does not use are zeroed
    always_comb
    begin
        push_item.is_cmd = (action != i2cmbe_pkg::OP_IDLE);
        push_item.op     = action;
        push_item.data   = (action == i2cmbe_pkg::OP_WRITE) ? data_byte : 8'd0;
        push_item.ackr   = (action == i2cmbe_pkg::OP_READ) ? ack_after_read : 1'b0;
        push_item.sda    = (action == i2cmbe_pkg::OP_IDLE) ? sda_in : 1'b0;
    end

endmodule

[hw/rtl/i2cmbe_queue.sv]
// Two-entry queue between the front end and the engine.
`timescale 1ns / 1ps

module i2cmbe_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  i2cmbe_pkg::item_t   push_item,
    output logic                full,
    input  logic                pop,
    output logic                q_valid,
    output i2cmbe_pkg::item_t   q_item
);

    i2cmbe_pkg::item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hw/rtl/i2cmbe_back.sv]
// Engine: bus phase machine, shift register and the registered result.
`timescale 1ns / 1ps

module i2cmbe_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_ack_timeout,
    input  logic                q_valid,
    input  i2cmbe_pkg::item_t   q_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                scl_level,
    output logic                sda_release,
    output logic                busy_res,
    output logic                done_res,
    output logic [7:0]          read_data,
    output logic                ack_error,
    output logic                rejected
);

    logic [7:0] timeout_reg;
    logic [2:0] op_reg, op_next;
    logic [1:0] phase_reg, phase_next;
    logic [3:0] bits_reg, bits_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] poll_reg, poll_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       ackc_reg, ackc_next;
    logic [7:0] hold_reg, hold_next;
    logic       err_reg, err_next;
    logic       done_next, rej_next;

    logic       out_valid_reg;
    logic       done_out_reg, rej_out_reg;

    logic [3:0] bits_inc;
    logic [7:0] rd_shift;

    assign cfg_ready = 1'b1;
    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign bits_inc  = bits_reg + 4'd1;
    assign rd_shift  = {shift_reg[6:0], q_item.sda};

    // Timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= i2cmbe_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            timeout_reg <= cfg_ack_timeout;
        end
    end

    // Next state for one beat
    always_comb
    begin
        op_next    = op_reg;
        phase_next = phase_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        poll_next  = poll_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ackc_next  = ackc_reg;
        hold_next  = hold_reg;
        err_next   = err_reg;
        done_next  = 1'b0;
        rej_next   = 1'b0;

        if (q_item.is_cmd)
        begin
            if (op_reg != i2cmbe_pkg::OP_IDLE)
            begin
                rej_next = 1'b1;
            end
            else
            begin
                // Command start: first bus levels
                err_next   = 1'b0;
                op_next    = q_item.op;
                phase_next = 2'd0;
                bits_next  = 4'd0;
                unique case (q_item.op)
                    i2cmbe_pkg::OP_START:
                    begin
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                    end
                    i2cmbe_pkg::OP_STOP:
                    begin
                        scl_next = 1'b0;
                        sda_next = 1'b0;
                    end
                    i2cmbe_pkg::OP_WRITE:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = q_item.data[7];
                        shift_next = {q_item.data[6:0], 1'b0};
                    end
                    i2cmbe_pkg::OP_READ:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        shift_next = 8'd0;
                        ackc_next  = q_item.ackr;
                    end
                    i2cmbe_pkg::OP_WAIT:
                    begin
                        sda_next  = 1'b1;
                        poll_next = 8'd0;
                    end
                    i2cmbe_pkg::OP_ACK:
                    begin
                        scl_next = 1'b0;
                        sda_next = 1'b0;
                    end
                    default:
                    begin
                        scl_next = 1'b0;
                        sda_next = 1'b1;
                    end
                endcase
            end
        end
        else if (op_reg != i2cmbe_pkg::OP_IDLE)
        begin
            // Tick: advance one phase
            unique case (op_reg)
                i2cmbe_pkg::OP_START:
                begin
                    if (phase_reg == 2'd0)
                    begin
                        sda_next   = 1'b0;
                        phase_next = 2'd1;
                    end
                    else
                    begin
                        scl_next  = 1'b0;
                        done_next = 1'b1;
                    end
                end
                i2cmbe_pkg::OP_STOP:
                begin
                    if (phase_reg == 2'd0)
                    begin
                        scl_next   = 1'b1;
                        phase_next = 2'd1;
                    end
                    else if (phase_reg == 2'd1)
                    begin
                        sda_next   = 1'b1;
                        phase_next = 2'd2;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
                i2cmbe_pkg::OP_WRITE:
                begin
                    if (phase_reg == 2'd0)
                    begin
                        scl_next   = 1'b1;
                        phase_next = 2'd1;
                    end
                    else
                    begin
                        scl_next  = 1'b0;
                        bits_next = bits_inc;
                        if (bits_inc >= i2cmbe_pkg::BITS_PER_BYTE)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            sda_next   = shift_reg[7];
                            shift_next = {shift_reg[6:0], 1'b0};
                            phase_next = 2'd0;
                        end
                    end
                end
                i2cmbe_pkg::OP_READ:
                begin
                    if (phase_reg == 2'd0)
                    begin
                        scl_next   = 1'b1;
                        phase_next = 2'd1;
                    end
                    else if (phase_reg == 2'd1)
                    begin
                        // Sample at the end of SCL high
                        shift_next = rd_shift;
                        scl_next   = 1'b0;
                        bits_next  = bits_inc;
                        if (bits_inc >= i2cmbe_pkg::BITS_PER_BYTE)
                        begin
                            hold_next  = rd_shift;
                            sda_next   = !ackc_reg;
                            phase_next = 2'd2;
                        end
                        else
                        begin
                            phase_next = 2'd0;
                        end
                    end
                    else if (phase_reg == 2'd2)
                    begin
                        scl_next   = 1'b1;
                        phase_next = 2'd3;
                    end
                    else
                    begin
                        scl_next  = 1'b0;
                        done_next = 1'b1;
                    end
                end
                i2cmbe_pkg::OP_WAIT:
                begin
                    if (phase_reg == 2'd0)
                    begin
                        scl_next   = 1'b1;
                        phase_next = 2'd1;
                    end
                    else if (!q_item.sda)
                    begin
                        scl_next  = 1'b0;
                        done_next = 1'b1;
                    end
                    else if (poll_reg >= timeout_reg)
                    begin
                        // Timed out: flag and fall into a stop
                        err_next   = 1'b1;
                        op_next    = i2cmbe_pkg::OP_STOP;
                        phase_next = 2'd0;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                    end
                    else
                    begin
                        poll_next = poll_reg + 8'd1;
                    end
                end
                i2cmbe_pkg::OP_ACK, i2cmbe_pkg::OP_NACK:
                begin
                    if (phase_reg == 2'd0)
                    begin
                        scl_next   = 1'b1;
                        phase_next = 2'd1;
                    end
                    else
                    begin
                        scl_next  = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    done_next = 1'b1;
                end
            endcase

            if (done_next)
            begin
                op_next    = i2cmbe_pkg::OP_IDLE;
                phase_next = 2'd0;
            end
        end
    end

    // Engine state, updated on each beat taken from the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= i2cmbe_pkg::OP_IDLE;
            phase_reg <= 2'd0;
            bits_reg  <= 4'd0;
            shift_reg <= 8'd0;
            poll_reg  <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ackc_reg  <= 1'b0;
            hold_reg  <= 8'd0;
            err_reg   <= 1'b0;
        end
        else if (pop)
        begin
            op_reg    <= op_next;
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            poll_reg  <= poll_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ackc_reg  <= ackc_next;
            hold_reg  <= hold_next;
            err_reg   <= err_next;
        end
    end

    // Output register: holds a result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            done_out_reg <= done_next;
            rej_out_reg  <= rej_next;
        end
    end

    // Level fields mirror the engine state after the last beat
    assign out_valid   = out_valid_reg;
    assign scl_level   = scl_reg;
    assign sda_release = sda_reg;
    assign busy_res    = (op_reg != i2cmbe_pkg::OP_IDLE);
    assign done_res    = done_out_reg;
    assign read_data   = hold_reg;
    assign ack_error   = err_reg;
    assign rejected    = rej_out_reg;

endmodule

[hw/rtl/i2c_master_byte_engine.sv]
// Top level of the I2C master byte engine.
`timescale 1ns / 1ps

// I2C master byte engine.
// Input channel (in_valid/in_ready): one beat is a command (start, stop,
// write byte, read byte, wait ack, send ack, send nack) or a tick, which
// stands for one half-bit delay and carries the sampled SDA level.
// Every input beat yields exactly one result beat on the output channel
// (out_valid/out_ready): SCL and SDA drive levels, busy, done, last read
// byte, acknowledge error and a flag for a command refused while busy.
// Configuration channel (cfg_valid/cfg_ready) writes the acknowledge
// timeout and is always ready; the timeout must be written only while
// the block is idle, which the block itself does not enforce.
// Throughput: one beat per cycle while results are taken. A beat is
// registered in the front queue, then in the engine, which sets the rate.
// When the receiver stalls, the result is held in the output register and
// the two-entry queue absorbs up to two more beats before in_ready drops.
// Reset: both lines released, engine idle, queue empty, timeout 250, read
// byte zero.

module i2c_master_byte_engine (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_ack_timeout,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] action,
    input  logic [7:0] data_byte,
    input  logic       ack_after_read,
    input  logic       sda_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       scl_level,
    output logic       sda_release,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] read_data,
    output logic       ack_error,
    output logic       rejected
);

    logic              push;
    logic              q_full;
    logic              pop;
    logic              q_valid;
    i2cmbe_pkg::item_t push_item;
    i2cmbe_pkg::item_t q_item;

    i2cmbe_front u_front (
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .data_byte      (data_byte),
        .ack_after_read (ack_after_read),
        .sda_in         (sda_in),
        .push           (push),
        .push_item      (push_item),
        .q_full         (q_full)
    );

    i2cmbe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    i2cmbe_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_ack_timeout (cfg_ack_timeout),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .scl_level       (scl_level),
        .sda_release     (sda_release),
        .busy_res        (busy_res),
        .done_res        (done_res),
        .read_data       (read_data),
        .ack_error       (ack_error),
        .rejected        (rejected)
    );

endmodule
